### rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

   // Which diagonal element leads the conversion.
   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

endpackage

### rtl/rmq_front.sv
// Front stage: trace, branch select, radicand clamp and numerators.
module rmq_front #(
   parameter int DW = 16,
   parameter int FB = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic signed [DW-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22,
   output logic                  out_vld,
   output rmq_pkg::branch_type   out_br,
   output logic        [DW+2:0]  out_rad,
   output logic signed [DW+1:0]  out_n0, out_n1, out_n2,
   output logic                  out_degen
);
   import rmq_pkg::*;

   localparam int RW = DW + 3;

   logic signed [RW-1:0] trace, rad, one;
   logic signed [DW+1:0] n0, n1, n2;
   branch_type           br;
   logic                 vld_ff;
   branch_type           br_ff;
   logic        [RW-1:0] rad_ff;
   logic signed [DW+1:0] n0_ff, n1_ff, n2_ff;
   logic                 degen_ff;

   always_comb begin
      one   = RW'(1) <<< FB;
      trace = RW'(m00) + RW'(m11) + RW'(m22);
      if (trace > 0) begin
         br  = BR_TRACE;
         rad = one + trace;
         n0  = (DW+2)'(m21) - (DW+2)'(m12);
         n1  = (DW+2)'(m02) - (DW+2)'(m20);
         n2  = (DW+2)'(m10) - (DW+2)'(m01);
      end else if (m00 > m11 && m00 > m22) begin
         br  = BR_X;
         rad = one + RW'(m00) - RW'(m11) - RW'(m22);
         n0  = (DW+2)'(m21) - (DW+2)'(m12);
         n1  = (DW+2)'(m01) + (DW+2)'(m10);
         n2  = (DW+2)'(m02) + (DW+2)'(m20);
      end else if (m11 > m22) begin
         br  = BR_Y;
         rad = one + RW'(m11) - RW'(m00) - RW'(m22);
         n0  = (DW+2)'(m02) - (DW+2)'(m20);
         n1  = (DW+2)'(m01) + (DW+2)'(m10);
         n2  = (DW+2)'(m12) + (DW+2)'(m21);
      end else begin
         br  = BR_Z;
         rad = one + RW'(m22) - RW'(m00) - RW'(m11);
         n0  = (DW+2)'(m10) - (DW+2)'(m01);
         n1  = (DW+2)'(m02) + (DW+2)'(m20);
         n2  = (DW+2)'(m12) + (DW+2)'(m21);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      br_ff    <= br;
      n0_ff    <= n0;
      n1_ff    <= n1;
      n2_ff    <= n2;
      degen_ff <= (rad <= 0);
      rad_ff   <= (rad <= 0) ? RW'(1) : rad;
   end

   assign out_vld   = vld_ff;
   assign out_br    = br_ff;
   assign out_rad   = rad_ff;
   assign out_n0    = n0_ff;
   assign out_n1    = n1_ff;
   assign out_n2    = n2_ff;
   assign out_degen = degen_ff;
endmodule

### rtl/rmq_sqrt.sv
// Pipelined restoring square root, one result bit per stage, sideband carried.
module rmq_sqrt #(
   parameter int IW = 38,   // radicand bits, even
   parameter int SB = 8     // sideband bits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [IW-1:0]     in_rad,
   input  logic [SB-1:0]     in_side,
   output logic              out_vld,
   output logic [IW/2-1:0]   out_root,
   output logic [SB-1:0]     out_side
);
   localparam int N  = IW / 2;
   localparam int RM = N + 2;

   logic          vld_ff  [N];
   logic [IW-1:0] val_ff  [N];
   logic [RM-1:0] rem_ff  [N];
   logic [N-1:0]  root_ff [N];
   logic [SB-1:0] side_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_stg
      logic          st_vld;
      logic [IW-1:0] st_val;
      logic [RM-1:0] st_rem;
      logic [N-1:0]  st_root;
      logic [SB-1:0] st_side;
      logic [RM-1:0] rem_in, trial;

      if (s == 0) begin : g_head
         assign st_vld  = in_vld;
         assign st_val  = in_rad;
         assign st_rem  = '0;
         assign st_root = '0;
         assign st_side = in_side;
      end else begin : g_body
         assign st_vld  = vld_ff[s-1];
         assign st_val  = val_ff[s-1];
         assign st_rem  = rem_ff[s-1];
         assign st_root = root_ff[s-1];
         assign st_side = side_ff[s-1];
      end

      always_comb begin
         rem_in = {st_rem[RM-3:0], st_val[IW-1 -: 2]};
         trial  = {st_root, 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= st_vld;
         end
         val_ff[s]  <= st_val << 2;
         side_ff[s] <= st_side;
         if (rem_in >= trial) begin
            rem_ff[s]  <= rem_in - trial;
            root_ff[s] <= {st_root[N-2:0], 1'b1};
         end else begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {st_root[N-2:0], 1'b0};
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_side = side_ff[N-1];
endmodule

### rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and signed.
module rmq_div #(
   parameter int NW = 18,   // numerator bits, signed
   parameter int DVW = 19,  // divisor bits
   parameter int FB = 14,
   parameter int QW = 34    // quotient bits produced
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic signed [NW-1:0] in_num,
   input  logic [DVW-1:0]       in_den,
   output logic                 out_vld,
   output logic signed [QW:0]   out_q
);
   // dividend = |n| << (FB+1) ; QW bits of quotient
   localparam int DDW = QW;
   localparam int RW  = DVW + 1;

   logic           vld_ff [QW];
   logic           neg_ff [QW];
   logic [DDW-1:0] dd_ff  [QW];
   logic [RW-1:0]  rem_ff [QW];
   logic [QW-1:0]  q_ff   [QW];
   logic [DVW-1:0] den_ff [QW];
   logic [NW-1:0]  mag;
   logic [DDW-1:0] dd_head;
   logic [QW-1:0]  qr;

   always_comb begin
      mag     = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
      dd_head = DDW'(mag) << (FB + 1);
   end

   for (genvar s = 0; s < QW; s++) begin : g_stg
      logic           st_vld, st_neg;
      logic [DDW-1:0] st_dd;
      logic [RW-1:0]  st_rem;
      logic [QW-1:0]  st_q;
      logic [DVW-1:0] st_den;
      logic [RW-1:0]  r_in;

      if (s == 0) begin : g_head
         assign st_vld = in_vld;
         assign st_neg = in_num[NW-1];
         assign st_dd  = dd_head;
         assign st_rem = '0;
         assign st_q   = '0;
         assign st_den = in_den;
      end else begin : g_body
         assign st_vld = vld_ff[s-1];
         assign st_neg = neg_ff[s-1];
         assign st_dd  = dd_ff[s-1];
         assign st_rem = rem_ff[s-1];
         assign st_q   = q_ff[s-1];
         assign st_den = den_ff[s-1];
      end

      always_comb r_in = {st_rem[RW-2:0], st_dd[DDW-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= st_vld;
         end
         neg_ff[s] <= st_neg;
         den_ff[s] <= st_den;
         dd_ff[s]  <= st_dd << 1;
         if (r_in >= RW'(st_den)) begin
            rem_ff[s] <= r_in - RW'(st_den);
            q_ff[s]   <= {st_q[QW-2:0], 1'b1};
         end else begin
            rem_ff[s] <= r_in;
            q_ff[s]   <= {st_q[QW-2:0], 1'b0};
         end
      end
   end

   assign out_vld = vld_ff[QW-1];

   always_comb begin
      qr    = QW'((QW+1)'(q_ff[QW-1]) + (QW+1)'(1) >> 1);
      out_q = neg_ff[QW-1] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
   end
endmodule

### rtl/rotation_matrix_to_quaternion_unit.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Usage: drive the nine Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS rotation elements on
// req_r00..req_r22 and raise start. busy is always low, so a beat is taken on
// every cycle that start is high: one item per clock, back to back.
// Each beat walks a front stage (branch select, radicand, numerators), a
// bit-per-stage square root of RTW stages (18 at the default widths), then
// three parallel bit-per-stage dividers of QW = DATA_WIDTH + FRAC_BITS + 3
// stages (33 at defaults), and an output register.
// A result shows for one cycle on rsp_* with rsp_valid high; the receiver
// cannot stall, so nothing ever backs up.
// Degenerate (non-positive) radicands are clamped to one LSB, rsp_degenerate.
// Reset (synchronous, active high) clears all valid bits; data in flight is
// dropped, payload registers are not cleared.
module rotation_matrix_to_quaternion_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_r00, req_r01, req_r02,
   input  logic signed [DATA_WIDTH-1:0] req_r10, req_r11, req_r12,
   input  logic signed [DATA_WIDTH-1:0] req_r20, req_r21, req_r22,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z,
   output logic                         rsp_degenerate
);
   import rmq_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int RW  = DW + 3;                        // radicand bits
   localparam int SH  = FRAC_BITS + 2;                 // root input scale
   localparam int SIW = ((RW + SH + 1) / 2) * 2;       // even root input width
   localparam int RTW = SIW / 2;                       // root bits
   localparam int NW  = DW + 2;
   localparam int QW  = NW + FRAC_BITS + 1;            // quotient bits
   localparam int SB  = 2 + 1 + 3 * NW;                // sideband through root
   localparam int MAXV = (1 << (DW - 1)) - 1;

   // front
   logic               f_vld, f_degen;
   branch_type         f_br;
   logic [RW-1:0]      f_rad;
   logic signed [NW-1:0] f_n0, f_n1, f_n2;

   assign busy = 1'b0;

   rmq_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
      .clock, .reset, .in_vld(start),
      .m00(req_r00), .m01(req_r01), .m02(req_r02),
      .m10(req_r10), .m11(req_r11), .m12(req_r12),
      .m20(req_r20), .m21(req_r21), .m22(req_r22),
      .out_vld(f_vld), .out_br(f_br), .out_rad(f_rad),
      .out_n0(f_n0), .out_n1(f_n1), .out_n2(f_n2), .out_degen(f_degen)
   );

   // root: floor(sqrt(R * 2^(FRAC_BITS+2)))
   logic            s_vld;
   logic [RTW-1:0]  s_root;
   logic [SB-1:0]   s_side;

   rmq_sqrt #(.IW(SIW), .SB(SB)) u_sqrt (
      .clock, .reset, .in_vld(f_vld),
      .in_rad(SIW'(f_rad) << SH),
      .in_side({f_br, f_degen, f_n0, f_n1, f_n2}),
      .out_vld(s_vld), .out_root(s_root), .out_side(s_side)
   );

   logic [1:0]           s_br;
   logic                 s_degen;
   logic signed [NW-1:0] s_n0, s_n1, s_n2;
   assign {s_br, s_degen, s_n0, s_n1, s_n2} = s_side;

   // dividers (three lanes) plus matching delay line for control and diagonal
   logic signed [QW:0] c0, c1, c2;
   logic               d0_vld, d1_vld, d2_vld;

   rmq_div #(.NW(NW), .DVW(RTW), .FB(FRAC_BITS), .QW(QW)) u_div0 (
      .clock, .reset, .in_vld(s_vld), .in_num(s_n0), .in_den(s_root),
      .out_vld(d0_vld), .out_q(c0));
   rmq_div #(.NW(NW), .DVW(RTW), .FB(FRAC_BITS), .QW(QW)) u_div1 (
      .clock, .reset, .in_vld(s_vld), .in_num(s_n1), .in_den(s_root),
      .out_vld(d1_vld), .out_q(c1));
   rmq_div #(.NW(NW), .DVW(RTW), .FB(FRAC_BITS), .QW(QW)) u_div2 (
      .clock, .reset, .in_vld(s_vld), .in_num(s_n2), .in_den(s_root),
      .out_vld(d2_vld), .out_q(c2));

   logic             dl_vld_ff  [QW];
   logic [1:0]       dl_br_ff   [QW];
   logic             dl_dg_ff   [QW];
   logic [RTW-1:0]   dl_d_ff    [QW];
   logic [RTW-1:0]   s_diag;

   // diagonal component (r2 + 2) >> 2
   assign s_diag = RTW'(({1'b0, s_root} + (RTW+1)'(2)) >> 2);

   for (genvar k = 0; k < QW; k++) begin : g_dly
      logic           st_vld, st_dg;
      logic [1:0]     st_br;
      logic [RTW-1:0] st_d;

      if (k == 0) begin : g_head
         assign st_vld = s_vld;
         assign st_br  = s_br;
         assign st_dg  = s_degen;
         assign st_d   = s_diag;
      end else begin : g_body
         assign st_vld = dl_vld_ff[k-1];
         assign st_br  = dl_br_ff[k-1];
         assign st_dg  = dl_dg_ff[k-1];
         assign st_d   = dl_d_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dl_vld_ff[k] <= 1'b0;
         end else begin
            dl_vld_ff[k] <= st_vld;
         end
         dl_br_ff[k] <= st_br;
         dl_dg_ff[k] <= st_dg;
         dl_d_ff[k]  <= st_d;
      end
   end

   function automatic logic [DW-1:0] sat_q(input logic signed [QW:0] v);
      if (v > (QW+1)'(MAXV))
         sat_q = DW'(MAXV);
      else if (v < -(QW+1)'(MAXV) - (QW+1)'(1))
         sat_q = DW'(-MAXV - 1);
      else
         sat_q = v[DW-1:0];
   endfunction

   logic [DW-1:0] pd, p0, p1, p2;
   logic [DW-1:0] w_in, x_in, y_in, z_in;
   logic          vld_ff, dg_ff;
   logic [DW-1:0] w_ff, x_ff, y_ff, z_ff;

   always_comb begin
      pd = sat_q((QW+1)'(dl_d_ff[QW-1]));
      p0 = sat_q(c0);
      p1 = sat_q(c1);
      p2 = sat_q(c2);
      case (branch_type'(dl_br_ff[QW-1]))
         BR_TRACE: begin w_in = pd; x_in = p0; y_in = p1; z_in = p2; end
         BR_X:     begin w_in = p0; x_in = pd; y_in = p1; z_in = p2; end
         BR_Y:     begin w_in = p0; x_in = p1; y_in = pd; z_in = p2; end
         default:  begin w_in = p0; x_in = p1; y_in = p2; z_in = pd; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= dl_vld_ff[QW-1];
      end
      dg_ff <= dl_dg_ff[QW-1];
      w_ff  <= w_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_degenerate = dg_ff;
   assign rsp_quat_w     = w_ff;
   assign rsp_quat_x     = x_ff;
   assign rsp_quat_y     = y_ff;
   assign rsp_quat_z     = z_ff;

   // checks
   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_rst_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
   a_front_vld: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> f_vld)
      else $error("front lost a beat");
   a_lane_align: assert property (@(posedge clock) disable iff (reset)
      (d0_vld && d1_vld && d2_vld) == dl_vld_ff[QW-1])
      else $error("divider lanes out of step with delay line");
endmodule

### tb/rotation_matrix_to_quaternion_unit_test.sv
// Self-checking testbench for the rotation matrix to quaternion unit.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_unit_test;
   import rmq_pkg::*;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int TAIL_CYCLES = 200;   // well beyond the pipeline depth
   localparam int RAND_BEATS = 750;

   typedef logic signed [DW-1:0] elem_type;

   typedef struct {
      elem_type m [9];
   } matrix_type;

   typedef struct {
      elem_type w, x, y, z;
      logic     degen;
   } quat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   elem_type req_r00 = '0, req_r01 = '0, req_r02 = '0;
   elem_type req_r10 = '0, req_r11 = '0, req_r12 = '0;
   elem_type req_r20 = '0, req_r21 = '0, req_r22 = '0;
   logic     rsp_valid;
   elem_type rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic     rsp_degenerate;

   matrix_type pending_mats [$];
   quat_type   expected_quats [$];
   int         fail_count = 0;
   bit         stim_done = 1'b0;
   bit         hold_off = 1'b0;    // sender pause requested by the stimulus
   int         burst_left = 0;
   int         gap_left = 0;

   rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(req_r00), .req_r01(req_r01), .req_r02(req_r02),
      .req_r10(req_r10), .req_r11(req_r11), .req_r12(req_r12),
      .req_r20(req_r20), .req_r21(req_r21), .req_r22(req_r22),
      .rsp_valid(rsp_valid), .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_degenerate(rsp_degenerate)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Saturate to the output word.
   function automatic elem_type clip(longint v);
      longint hi;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      if (v > hi) return elem_type'(hi);
      if (v < -hi - 1) return elem_type'(-hi - 1);
      return elem_type'(v);
   endfunction

   // floor(sqrt(rad * 2^(FB+2))), bit by bit.
   function automatic longint unsigned twice_root(longint unsigned rad);
      longint unsigned arg, rem, root, trial;
      arg = rad << (FB + 2);
      rem = 0;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         rem = (rem << 2) | ((arg >> (2 * i)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // round(num * 2^FB / den), half away from zero.
   function automatic longint scaled_quotient(longint num, longint unsigned den);
      longint unsigned mag, q, rem;
      mag = (num < 0) ? longint'(-num) : num;
      q = mag / den;
      rem = mag % den;
      for (int i = 0; i <= FB; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem -= den;
            q |= 64'd1;
         end
      end
      q = (q + 64'd1) >> 1;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type mt);
      longint e [9];
      longint one, trace, rad, n0, n1, n2, diag_c, c0, c1, c2;
      longint unsigned r2;
      branch_type br;
      quat_type q;
      for (int i = 0; i < 9; i++) e[i] = longint'(mt.m[i]);
      one = longint'(1) <<< FB;
      trace = e[0] + e[4] + e[8];
      if (trace > 0) begin
         br = BR_TRACE; rad = one + trace;
         n0 = e[7] - e[5]; n1 = e[2] - e[6]; n2 = e[3] - e[1];
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         br = BR_X; rad = one + e[0] - e[4] - e[8];
         n0 = e[7] - e[5]; n1 = e[1] + e[3]; n2 = e[2] + e[6];
      end else if (e[4] > e[8]) begin
         br = BR_Y; rad = one + e[4] - e[0] - e[8];
         n0 = e[2] - e[6]; n1 = e[1] + e[3]; n2 = e[5] + e[7];
      end else begin
         br = BR_Z; rad = one + e[8] - e[0] - e[4];
         n0 = e[3] - e[1]; n1 = e[2] + e[6]; n2 = e[5] + e[7];
      end
      q.degen = (rad <= 0);
      if (rad <= 0) rad = 1;   // clamp a non-rotation radicand to one LSB
      r2 = twice_root(rad);
      diag_c = longint'((r2 + 64'd2) >> 2);
      c0 = scaled_quotient(n0, r2);
      c1 = scaled_quotient(n1, r2);
      c2 = scaled_quotient(n2, r2);
      case (br)
         BR_TRACE: begin
            q.w = clip(diag_c); q.x = clip(c0); q.y = clip(c1); q.z = clip(c2);
         end
         BR_X: begin
            q.w = clip(c0); q.x = clip(diag_c); q.y = clip(c1); q.z = clip(c2);
         end
         BR_Y: begin
            q.w = clip(c0); q.x = clip(c1); q.y = clip(diag_c); q.z = clip(c2);
         end
         default: begin
            q.w = clip(c0); q.x = clip(c1); q.y = clip(c2); q.z = clip(diag_c);
         end
      endcase
      return q;
   endfunction

   // Driver: pops a pending matrix each beat; bursts and gaps set the pace.
   always @(posedge clock) begin
      matrix_type hd;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // a beat is taken at this edge when start was high and busy low
         if (start && !busy) begin
            expected_quats.push_back(matrix_to_quat(pending_mats.pop_front()));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (hold_off || pending_mats.size() == 0) begin
            start <= 1'b0;
         end else begin
            // keep start high across the burst; drive the next matrix
            if (start && !busy) begin
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  if ($urandom_range(0, 3) == 0) begin
                     gap_left <= $urandom_range(1, 12);
                     start <= 1'b0;
                  end else begin
                     start <= 1'b1;
                  end
               end else begin
                  burst_left <= burst_left - 1;
                  start <= 1'b1;
               end
            end else begin
               start <= 1'b1;
            end
         end
         // data follows the queue head, so whatever start shows is the next beat
         if (pending_mats.size() > 0) begin
            hd = pending_mats[0];
            req_r00 <= hd.m[0]; req_r01 <= hd.m[1]; req_r02 <= hd.m[2];
            req_r10 <= hd.m[3]; req_r11 <= hd.m[4]; req_r12 <= hd.m[5];
            req_r20 <= hd.m[6]; req_r21 <= hd.m[7]; req_r22 <= hd.m[8];
         end
      end
   end

   // Monitor: each strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected result beat w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            fail_count++;
         end else begin
            want = expected_quats.pop_front();
            if (rsp_quat_w !== want.w) begin
               $display("%0t: quat_w expected %0d got %0d", $time, want.w, rsp_quat_w);
               fail_count++;
            end
            if (rsp_quat_x !== want.x) begin
               $display("%0t: quat_x expected %0d got %0d", $time, want.x, rsp_quat_x);
               fail_count++;
            end
            if (rsp_quat_y !== want.y) begin
               $display("%0t: quat_y expected %0d got %0d", $time, want.y, rsp_quat_y);
               fail_count++;
            end
            if (rsp_quat_z !== want.z) begin
               $display("%0t: quat_z expected %0d got %0d", $time, want.z, rsp_quat_z);
               fail_count++;
            end
            if (rsp_degenerate !== want.degen) begin
               $display("%0t: degenerate expected %0b got %0b", $time, want.degen,
                        rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

   function automatic matrix_type make_mat(int a0, int a1, int a2, int a3, int a4,
                                           int a5, int a6, int a7, int a8);
      matrix_type mt;
      mt.m[0] = elem_type'(a0); mt.m[1] = elem_type'(a1); mt.m[2] = elem_type'(a2);
      mt.m[3] = elem_type'(a3); mt.m[4] = elem_type'(a4); mt.m[5] = elem_type'(a5);
      mt.m[6] = elem_type'(a6); mt.m[7] = elem_type'(a7); mt.m[8] = elem_type'(a8);
      return mt;
   endfunction

   // Near-rotation: random diagonal pattern plus off-diagonals within +/-1.0,
   // so every branch sees well-formed radicands.
   function automatic matrix_type rand_pose();
      matrix_type mt;
      int one;
      one = 1 << FB;
      for (int i = 0; i < 9; i++) mt.m[i] = elem_type'($urandom_range(0, 2 * one) - one);
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            mt.m[0] = elem_type'(one - $urandom_range(0, 900));
            mt.m[4] = elem_type'(-mt.m[4] / 2 - one / 2);
         end
         2: begin
            mt.m[4] = elem_type'(one - $urandom_range(0, 900));
            mt.m[0] = elem_type'(-one / 2);
         end
         default: begin
            mt.m[8] = elem_type'(one - $urandom_range(0, 900));
            mt.m[0] = elem_type'(-one / 2);
         end
      endcase
      return mt;
   endfunction

   initial begin
      matrix_type mt;
      int one, mx, mn;
      one = 1 << FB;
      mx = 32767;
      mn = -32768;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, each branch, extremes, ties
      pending_mats.push_back(make_mat(one, 0, 0, 0, one, 0, 0, 0, one));
      pending_mats.push_back(make_mat(one, 0, 0, 0, -one, 0, 0, 0, -one));
      pending_mats.push_back(make_mat(-one, 0, 0, 0, one, 0, 0, 0, -one));
      pending_mats.push_back(make_mat(-one, 0, 0, 0, -one, 0, 0, 0, one));
      pending_mats.push_back(make_mat(mx, mx, mx, mx, mx, mx, mx, mx, mx));
      pending_mats.push_back(make_mat(mn, mn, mn, mn, mn, mn, mn, mn, mn));
      pending_mats.push_back(make_mat(mn, mx, mn, mx, mn, mx, mn, mx, mn));
      pending_mats.push_back(make_mat(mx, mn, mx, mn, mn, mn, mx, mn, mn));
      pending_mats.push_back(make_mat(0, mx, mn, mn, mn, mx, mx, mn, mx));
      pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_mats.push_back(make_mat(-100, 5, 6, 7, -100, 8, 9, 10, -200));
      pending_mats.push_back(make_mat(-100, 5, 6, 7, -200, 8, 9, 10, -100));
      pending_mats.push_back(make_mat(-50, 1, 2, 3, -50, 4, 5, 6, -50));
      pending_mats.push_back(make_mat(mn, 1, 2, 3, mn, 4, 5, 6, mn));
      pending_mats.push_back(make_mat(mn, mx, mx, mx, mn, mx, mx, mx, mn));
      pending_mats.push_back(make_mat(1, -1, 1, -1, 0, 1, -1, 1, -1));
      pending_mats.push_back(make_mat(-one, mx, mn, mn, mn, mx, mx, mn, -one));
      pending_mats.push_back(make_mat(-1, 0, 0, 0, 0, 0, 0, 0, 0));

      // pause the sender until the pipe is drained
      while (pending_mats.size() != 0 || start) @(posedge clock);
      hold_off = 1'b1;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat ($urandom_range(1, 5)) @(posedge clock);
      hold_off = 1'b0;

      for (int k = 0; k < RAND_BEATS; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 9; i++) mt.m[i] = elem_type'($urandom);   // raw noise
         end else begin
            mt = rand_pose();
         end
         pending_mats.push_back(mt);
         if ($urandom_range(0, 50) == 0) @(posedge clock);
      end
      stim_done = 1'b1;
   end

   initial begin
      while (!(stim_done && pending_mats.size() == 0 && !start &&
               expected_quats.size() == 0)) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_quats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
